/* hdl/indexed_heap_priority_queue_assert.svh */
// assertion macros for the indexed heap priority queue
`ifndef INDEXED_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IHPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ihpq_pkg.sv */
// types and codes shared by the indexed heap priority queue
`default_nettype none
package ihpq_pkg;

    localparam int KEY_W    = 32;
    localparam int ID_W     = 8;
    localparam int ID_COUNT = 256;
    localparam int LIVE_W   = 7;

    localparam logic [2:0] K_INSERT  = 3'd0;
    localparam logic [2:0] K_EXTRACT = 3'd1;
    localparam logic [2:0] K_PEEK    = 3'd2;
    localparam logic [2:0] K_UPDATE  = 3'd3;
    localparam logic [2:0] K_REMOVE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DUP_ID    = 3'd4;

    typedef struct packed {
        logic [2:0]              kind;
        logic [ID_W-1:0]         entry_id;
        logic signed [KEY_W-1:0] priority_key;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic [ID_W-1:0]         result_id;
        logic signed [KEY_W-1:0] result_key;
        logic [LIVE_W-1:0]       live_count;
    } t_out;

    typedef struct packed {
        logic                    del;
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } t_slot;

endpackage
`default_nettype wire

/* hdl/indexed_heap_priority_queue.sv */
// Indexed binary heap priority queue: the key comparators walk the heap one level per read
// and compare state pair (a registered slot-memory read, then compare and a single slot write),
// moving a hole instead of swapping. Every deleted entry met on top during extract or peek
// adds another top pop with its own sift down, unless it was the last entry. One transaction
// is worked on at a time; the next is taken once the result sits in the output register.
`default_nettype none
module indexed_heap_priority_queue
    import ihpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data
);
    localparam int SW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int CW = SW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_TOP_RD, S_TOP_CHK,
        S_LAST_RD, S_LAST_GET, S_POS_RD, S_UPD_RD, S_UPD, S_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_min;
    logic [UW-1:0]           r_used;
    logic [ID_COUNT-1:0]     r_present;
    logic [2:0]              r_kind;
    logic [ID_W-1:0]         r_id;
    logic signed [KEY_W-1:0] r_key;
    t_slot                   r_cur;
    logic [SW-1:0]           r_s;
    logic                    r_found;
    logic [2:0]              r_status;
    logic [ID_W-1:0]         r_rid;
    logic signed [KEY_W-1:0] r_rkey;
    t_out                    r_out;
    logic                    r_out_valid;

    t_slot           rd_a, rd_b, wdata;
    logic            we;
    logic [SW-1:0]   addr_a, addr_b;
    logic            pos_we;
    logic [ID_W-1:0] pos_raddr;
    logic [SW-1:0]   pos_rdata;
    logic [SW-1:0]   parent;
    logic [CW-1:0]   left, right;
    logic            lv, rv, c_l, c_r, up_stop, dn_stop, accept, out_load;
    logic signed [KEY_W-1:0] best_key;
    t_state          fin_next;

    function automatic logic better(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b,
                                    input logic                    min_first);
        return min_first ? (a < b) : (a > b);
    endfunction

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign parent = SW'((r_s - SW'(1)) >> 1);
    assign left   = CW'({r_s, 1'b1});
    assign right  = CW'({r_s, 1'b0}) + CW'(2);
    assign lv     = left < CW'(r_used);
    assign rv     = right < CW'(r_used);

    // child comparator path: pick the better child against the moving entry
    assign c_l      = lv && better(rd_a.key, r_cur.key, r_min);
    assign best_key = c_l ? rd_a.key : r_cur.key;
    assign c_r      = rv && better(rd_b.key, best_key, r_min);
    assign dn_stop  = !c_l && !c_r;
    assign up_stop  = (r_s == '0) || !better(r_cur.key, rd_a.key, r_min);

    assign fin_next = (!r_found && (r_kind == K_EXTRACT || r_kind == K_PEEK)) ? S_TOP_RD
                                                                             : S_DONE;

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        case (r_state)
            S_UP_RD:   addr_a = parent;
            S_DN_RD: begin
                addr_a = left[SW-1:0];
                addr_b = right[SW-1:0];
            end
            S_LAST_RD: addr_a = r_used[SW-1:0];
            S_UPD_RD: begin
                addr_a = parent;
                addr_b = r_s;
            end
            default:   addr_a = '0;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        wdata = r_cur;
        case (r_state)
            S_UP_CMP: begin
                we    = 1'b1;
                wdata = up_stop ? r_cur : rd_a;
            end
            S_DN_CMP: begin
                we    = 1'b1;
                wdata = c_r ? rd_b : (c_l ? rd_a : r_cur);
            end
            S_UPD: begin
                we    = (r_kind == K_REMOVE);
                wdata = '{del: 1'b1, id: rd_b.id, key: rd_b.key};
            end
            default: we = 1'b0;
        endcase
        // a deleted entry leaves the position table alone
        pos_we = we && !wdata.del;
    end

    assign pos_raddr = (r_state == S_IDLE) ? i_in.entry_id : r_id;

    ihpq_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY)) u_slot_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_s), .i_wdata(wdata),
        .i_raddr(addr_a), .o_rdata(rd_a)
    );

    ihpq_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY)) u_slot_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_s), .i_wdata(wdata),
        .i_raddr(addr_b), .o_rdata(rd_b)
    );

    ihpq_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(wdata.id), .i_wdata(r_s),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= 1'b1;
            r_used      <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind   <= i_in.kind;
                        r_id     <= i_in.entry_id;
                        r_key    <= i_in.priority_key;
                        r_status <= ST_OK;
                        r_rid    <= i_in.entry_id;
                        r_rkey   <= '0;
                        r_found  <= 1'b0;
                        r_state  <= S_DONE;
                        case (i_in.kind)
                            K_INSERT: begin
                                if (r_present[i_in.entry_id]) begin
                                    r_status <= ST_DUP_ID;
                                end else if (r_used >= UW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_present[i_in.entry_id] <= 1'b1;
                                    r_used <= r_used + UW'(1);
                                    r_cur  <= '{del: 1'b0, id: i_in.entry_id,
                                                key: i_in.priority_key};
                                    r_s     <= r_used[SW-1:0];
                                    r_state <= S_UP_RD;
                                end
                            end
                            K_EXTRACT, K_PEEK: begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_TOP_RD;
                            end
                            K_UPDATE, K_REMOVE: begin
                                if (!r_present[i_in.entry_id]) begin
                                    r_status <= ST_NOT_FOUND;
                                end else begin
                                    r_state <= S_POS_RD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_UP_RD:  r_state <= S_UP_CMP;
                S_UP_CMP: begin
                    if (up_stop) begin
                        r_state <= fin_next;
                    end else begin
                        r_s     <= parent;
                        r_state <= S_UP_RD;
                    end
                end
                S_DN_RD:  r_state <= S_DN_CMP;
                S_DN_CMP: begin
                    if (dn_stop) begin
                        r_state <= fin_next;
                    end else begin
                        r_s     <= c_r ? right[SW-1:0] : left[SW-1:0];
                        r_state <= S_DN_RD;
                    end
                end
                S_TOP_RD: begin
                    r_state <= (r_used == '0) ? S_DONE : S_TOP_CHK;
                end
                S_TOP_CHK: begin
                    if (!rd_a.del) begin
                        r_status <= ST_OK;
                        r_rid    <= rd_a.id;
                        r_rkey   <= rd_a.key;
                        r_found  <= 1'b1;
                    end
                    if (!rd_a.del && r_kind == K_PEEK) begin
                        r_state <= S_DONE;
                    end else begin
                        // pop the top slot
                        if (!rd_a.del) begin
                            r_present[rd_a.id] <= 1'b0;
                        end
                        r_used <= r_used - UW'(1);
                        if (r_used == UW'(1)) begin
                            r_state <= rd_a.del ? S_TOP_RD : S_DONE;
                        end else begin
                            r_state <= S_LAST_RD;
                        end
                    end
                end
                S_LAST_RD:  r_state <= S_LAST_GET;
                S_LAST_GET: begin
                    r_cur   <= rd_a;
                    r_s     <= '0;
                    r_state <= S_DN_RD;
                end
                S_POS_RD: begin
                    r_s     <= pos_rdata;
                    r_state <= S_UPD_RD;
                end
                S_UPD_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (r_kind == K_REMOVE) begin
                        r_present[r_id] <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= '{del: rd_b.del, id: rd_b.id, key: r_key};
                        if (r_s != '0 && better(r_key, rd_a.key, r_min)) begin
                            r_state <= S_UP_RD;
                        end else begin
                            r_state <= S_DN_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{status: r_status, result_id: r_rid, result_key: r_rkey,
                       live_count: LIVE_W'(r_used)};
        end
    end

`include "indexed_heap_priority_queue_assert.svh"

    `IHPQ_ASSERT_NEXT(a_busy_after_accept, accept, o_in_stall, "accepted transaction did not start")
    `IHPQ_ASSERT_NOW(a_used_bound, 1'b1, r_used <= UW'(CAPACITY), "slot count beyond capacity")
    `IHPQ_ASSERT_NEXT(a_result_shown, out_load, r_out_valid && !o_in_stall, "result not presented")

endmodule
`default_nettype wire

/* hdl/ihpq_ram.sv */
// generic single-port-write ram with one registered read port
`default_nettype none
module ihpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
